[rtl/nearest_point_tracker_assert.svh]
// Assertion macros for the nearest point tracker checker.
// Depends on a clock named clk and a synchronous reset named rst in the using scope.
`ifndef NEAREST_POINT_TRACKER_ASSERT_SVH
`define NEAREST_POINT_TRACKER_ASSERT_SVH

// Concurrent assertion that is switched off while reset is high.
`define NPT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Concurrent assertion that also holds across reset.
`define NPT_ASSERT_NR(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

[rtl/npt_pkg.sv]
// Shared types and constants for the nearest point tracker.
// No dependencies; used by the queue, front, back and top level.
`default_nettype none

package npt_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W = 1;

  localparam int REFRESH_CYCLES = 4;
  localparam int REFRESH_W = $clog2(REFRESH_CYCLES + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_X,
    CFG_TARGET_Y
  } cfg_idx_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } qstat_t;

endpackage

`default_nettype wire

[rtl/npt_fifo.sv]
// Short register queue between the distance front end and the winner back end.
// Depends on npt_pkg for its depth and status type.
`default_nettype none

module npt_fifo #(
  parameter int DATA_W = 102
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output npt_pkg::qstat_t   stat
);

  logic [DATA_W-1:0]              mem [npt_pkg::QDEPTH];
  logic [npt_pkg::QPTR_W-1:0]     wr_ptr;
  logic [npt_pkg::QPTR_W-1:0]     rd_ptr;
  logic [npt_pkg::QCNT_W-1:0]     count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign pop_data   = mem[rd_ptr];
  assign stat.count = count;
  assign stat.empty = (count == '0);

endmodule

`default_nettype wire

[rtl/npt_front.sv]
// Front end: accepts points and computes their axis and squared distances.
// Depends on npt_pkg for the queue status; feeds npt_fifo.
`default_nettype none

module npt_front #(
  parameter int W = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 point_valid,
  output logic                 point_stall,
  input  logic [W-1:0]         point_x,
  input  logic [W-1:0]         point_y,
  input  logic                 last_point,
  input  logic [W-1:0]         target_x,
  input  logic [W-1:0]         target_y,
  input  npt_pkg::qstat_t      qstat,
  output logic                 push,
  output logic [6*W+5:0]       push_data
);

  function automatic logic [W:0] absdiff(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] d;
    d = {a[W-1], a} - {b[W-1], b};
    absdiff = d[W] ? (~d + 1'b1) : d;
  endfunction

  logic                      accept;
  logic [npt_pkg::QCNT_W:0]  occ;

  logic           s1_valid;
  logic [W-1:0]   s1_px;
  logic [W-1:0]   s1_py;
  logic           s1_last;
  logic [W:0]     s1_adx;
  logic [W:0]     s1_ady;

  logic           s2_valid;
  logic [W-1:0]   s2_px;
  logic [W-1:0]   s2_py;
  logic           s2_last;
  logic [W:0]     s2_adx;
  logic [W:0]     s2_ady;
  logic [2*W+1:0] s2_sqx;
  logic [2*W+1:0] s2_sqy;
  logic [2*W+2:0] d2;

  // Items in flight plus queued items never exceed the queue depth.
  assign occ = {1'b0, qstat.count} + {{npt_pkg::QCNT_W{1'b0}}, s1_valid}
             + {{npt_pkg::QCNT_W{1'b0}}, s2_valid};
  assign point_stall = (occ >= (npt_pkg::QCNT_W + 1)'(npt_pkg::QDEPTH));
  assign accept = point_valid && !point_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_px   <= point_x;
    s1_py   <= point_y;
    s1_last <= last_point;
    s1_adx  <= absdiff(point_x, target_x);
    s1_ady  <= absdiff(point_y, target_y);
    s2_px   <= s1_px;
    s2_py   <= s1_py;
    s2_last <= s1_last;
    s2_adx  <= s1_adx;
    s2_ady  <= s1_ady;
    s2_sqx  <= s1_adx * s1_adx;
    s2_sqy  <= s1_ady * s1_ady;
  end

  assign d2        = {1'b0, s2_sqx} + {1'b0, s2_sqy};
  assign push      = s2_valid;
  assign push_data = {s2_last, d2, s2_ady, s2_adx, s2_py, s2_px};

endmodule

`default_nettype wire

[rtl/npt_back.sv]
// Back end: updates the three running winners and holds the result register.
// Depends on npt_pkg; drains npt_fifo.
`default_nettype none

module npt_back #(
  parameter int W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  npt_pkg::qstat_t  qstat,
  input  logic [6*W+5:0]   pop_data,
  output logic             pop,
  input  logic [W-1:0]     target_x,
  input  logic [W-1:0]     target_y,
  input  logic             cfg_write,
  output logic             result_valid,
  input  logic             result_stall,
  output logic [W-1:0]     nearx_px,
  output logic [W-1:0]     nearx_py,
  output logic [W-1:0]     neary_px,
  output logic [W-1:0]     neary_py,
  output logic [W-1:0]     nearest_px,
  output logic [W-1:0]     nearest_py
);

  function automatic logic [W:0] absdiff(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] d;
    d = {a[W-1], a} - {b[W-1], b};
    absdiff = d[W] ? (~d + 1'b1) : d;
  endfunction

  logic [W-1:0]   e_px;
  logic [W-1:0]   e_py;
  logic [W:0]     e_adx;
  logic [W:0]     e_ady;
  logic [2*W+2:0] e_d2;
  logic           e_last;

  logic           set_empty;
  logic [W-1:0]   bx_x, bx_y, by_x, by_y, bo_x, bo_y;
  logic [W:0]     dx_best;
  logic [W:0]     dy_best;
  logic [2*W+2:0] d2_best;

  logic [W-1:0]   bx_x_next, bx_y_next, by_x_next, by_y_next, bo_x_next, bo_y_next;
  logic [W:0]     dx_best_next;
  logic [W:0]     dy_best_next;
  logic [2*W+2:0] d2_best_next;
  logic           upd_x, upd_y, upd_o;

  logic [npt_pkg::REFRESH_W-1:0] refresh_cnt;

  logic [W:0]     h_adx, h_ady, h_aox, h_aoy;
  logic [2*W+1:0] h_sqx, h_sqy;
  logic [2*W+2:0] h_d2;

  assign {e_last, e_d2, e_ady, e_adx, e_py, e_px} = pop_data;

  assign pop = !qstat.empty && (refresh_cnt == '0)
            && (!e_last || !result_valid || !result_stall);

  always_comb begin
    upd_x = set_empty || (e_adx < dx_best);
    upd_y = set_empty || (e_ady < dy_best);
    upd_o = set_empty || (e_d2 < d2_best);
    bx_x_next    = upd_x ? e_px  : bx_x;
    bx_y_next    = upd_x ? e_py  : bx_y;
    dx_best_next = upd_x ? e_adx : dx_best;
    by_x_next    = upd_y ? e_px  : by_x;
    by_y_next    = upd_y ? e_py  : by_y;
    dy_best_next = upd_y ? e_ady : dy_best;
    bo_x_next    = upd_o ? e_px  : bo_x;
    bo_y_next    = upd_o ? e_py  : bo_y;
    d2_best_next = upd_o ? e_d2  : d2_best;
  end

  // The stored distances are recomputed from the stored winners after a target change.
  always_ff @(posedge clk) begin
    h_adx <= absdiff(bx_x, target_x);
    h_ady <= absdiff(by_y, target_y);
    h_aox <= absdiff(bo_x, target_x);
    h_aoy <= absdiff(bo_y, target_y);
    h_sqx <= h_aox * h_aox;
    h_sqy <= h_aoy * h_aoy;
    h_d2  <= {1'b0, h_sqx} + {1'b0, h_sqy};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_cnt  <= '0;
      set_empty    <= 1'b1;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        refresh_cnt <= npt_pkg::REFRESH_W'(npt_pkg::REFRESH_CYCLES);
      end else if (refresh_cnt != '0) begin
        refresh_cnt <= refresh_cnt - 1'b1;
      end
      if (pop) begin
        set_empty <= e_last;
      end
      if (pop && e_last) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (e_last) begin
        bx_x <= '0;
        bx_y <= '0;
        by_x <= '0;
        by_y <= '0;
        bo_x <= '0;
        bo_y <= '0;
        nearx_px   <= bx_x_next;
        nearx_py   <= bx_y_next;
        neary_px   <= by_x_next;
        neary_py   <= by_y_next;
        nearest_px <= bo_x_next;
        nearest_py <= bo_y_next;
      end else begin
        bx_x <= bx_x_next;
        bx_y <= bx_y_next;
        by_x <= by_x_next;
        by_y <= by_y_next;
        bo_x <= bo_x_next;
        bo_y <= bo_y_next;
      end
      dx_best <= dx_best_next;
      dy_best <= dy_best_next;
      d2_best <= d2_best_next;
    end else if (refresh_cnt == npt_pkg::REFRESH_W'(1)) begin
      dx_best <= h_adx;
      dy_best <= h_ady;
      d2_best <= h_d2;
    end
  end

endmodule

`default_nettype wire

[rtl/nearest_point_tracker.sv]
// Top level of the nearest point tracker: target registers, front end, queue, back end.
// Depends on npt_pkg, npt_front, npt_fifo and npt_back.
//
// Points arrive on the point channel (point_valid, point_stall) with signed
// coordinates point_x, point_y and a last_point flag that closes a set.
// A transfer on the point channel happens when point_valid is high and point_stall low.
// On each last point one result transfer follows on the result channel, carrying the
// points nearest the target in x, in y and by squared distance; ties keep the earlier point.
// From the transfer of a last point, the first distance stage loads at the transfer, then
// the second stage, the queue and the winner update follow in order before result_valid
// rises. One point is taken every cycle while point_stall is low.
// The target is written through cfg_valid, cfg_ready, cfg_index and cfg_data, which the
// user must do only while idle; the block does not enforce this. cfg_ready is always high.
// After each write the back end recomputes the stored winner distances; points stay queued.
// Reset clears the target to zero, empties the queue and the current set, and drops
// result_valid. While result_stall holds a result, points keep flowing until the next
// last point reaches the back end; the queue then fills and point_stall rises.
`default_nettype none

module nearest_point_tracker #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          point_valid,
  output logic                          point_stall,
  input  logic [COORD_WIDTH-1:0]        point_x,
  input  logic [COORD_WIDTH-1:0]        point_y,
  input  logic                          last_point,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [COORD_WIDTH-1:0]        nearx_px,
  output logic [COORD_WIDTH-1:0]        nearx_py,
  output logic [COORD_WIDTH-1:0]        neary_px,
  output logic [COORD_WIDTH-1:0]        neary_py,
  output logic [COORD_WIDTH-1:0]        nearest_px,
  output logic [COORD_WIDTH-1:0]        nearest_py,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [npt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data
);

  localparam int EW = 6 * COORD_WIDTH + 6;

  logic [COORD_WIDTH-1:0] target_x;
  logic [COORD_WIDTH-1:0] target_y;
  logic                   cfg_write;
  logic                   push;
  logic [EW-1:0]          push_data;
  logic                   pop;
  logic [EW-1:0]          pop_data;
  npt_pkg::qstat_t        qstat;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_x <= '0;
      target_y <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        npt_pkg::CFG_TARGET_X: target_x <= cfg_data;
        npt_pkg::CFG_TARGET_Y: target_y <= cfg_data;
        default: ;
      endcase
    end
  end

  npt_front #(.W(COORD_WIDTH)) u_front (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .point_x     (point_x),
    .point_y     (point_y),
    .last_point  (last_point),
    .target_x    (target_x),
    .target_y    (target_y),
    .qstat       (qstat),
    .push        (push),
    .push_data   (push_data)
  );

  npt_fifo #(.DATA_W(EW)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (qstat)
  );

  npt_back #(.W(COORD_WIDTH)) u_back (
    .clk          (clk),
    .rst          (rst),
    .qstat        (qstat),
    .pop_data     (pop_data),
    .pop          (pop),
    .target_x     (target_x),
    .target_y     (target_y),
    .cfg_write    (cfg_write),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .nearx_px     (nearx_px),
    .nearx_py     (nearx_py),
    .neary_px     (neary_px),
    .neary_py     (neary_py),
    .nearest_px   (nearest_px),
    .nearest_py   (nearest_py)
  );

endmodule

`default_nettype wire

[rtl/nearest_point_tracker_checker.sv]
// Port level checker for the nearest point tracker, bound to the top level.
// Depends on nearest_point_tracker_assert.svh for its assertion macros.
`include "nearest_point_tracker_assert.svh"
`default_nettype none

module nearest_point_tracker_checker #(
  parameter int COORD_WIDTH = 16
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   point_stall,
  input logic                   result_valid,
  input logic                   result_stall,
  input logic [COORD_WIDTH-1:0] nearx_px,
  input logic [COORD_WIDTH-1:0] nearx_py,
  input logic [COORD_WIDTH-1:0] neary_px,
  input logic [COORD_WIDTH-1:0] neary_py,
  input logic [COORD_WIDTH-1:0] nearest_px,
  input logic [COORD_WIDTH-1:0] nearest_py
);

  `NPT_ASSERT(a_result_holds, result_valid && result_stall |=> result_valid, "result dropped while stalled")
  `NPT_ASSERT(a_result_stable, result_valid && result_stall |=> $stable(nearx_px) && $stable(nearx_py) && $stable(neary_px) && $stable(neary_py) && $stable(nearest_px) && $stable(nearest_py), "result changed while stalled")
  `NPT_ASSERT_NR(a_reset_idle, rst |=> !result_valid && !point_stall, "block not idle after reset")

endmodule

bind nearest_point_tracker nearest_point_tracker_checker #(.COORD_WIDTH(COORD_WIDTH)) u_checker (.*);

`default_nettype wire
